[hw/rtl/swms_pkg.sv]
// Shared constants, widths, control struct and sequencer states for the
// sliding window mean / deviation block. No dependencies.
package swms_pkg;

   localparam int WINDOW_LEN = 50;
   localparam int NCHAN      = 6;
   localparam int SAMPLE_W   = 16;
   localparam int FRAC       = 4;
   localparam int CHAN_W     = 3;
   localparam int MEAN_W     = 20;
   localparam int DEV_W      = 21;

   localparam int POS_W    = $clog2(WINDOW_LEN);
   localparam int FILL_W   = $clog2(WINDOW_LEN + 1);
   localparam int WIN_W    = $clog2(WINDOW_LEN + 1);
   localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_LEN) + 1;
   localparam int ABS_W    = SUM_W - 1;
   localparam int SQ_W     = 2 * SAMPLE_W - 1;
   localparam int SQSUM_W  = SQ_W + $clog2(WINDOW_LEN);
   localparam int S2_W     = 2 * ABS_W;
   localparam int WQ_W     = SQSUM_W + WIN_W;
   localparam int MNUM_W   = ABS_W + FRAC;
   localparam int ROOT_W   = (WQ_W + 2 * FRAC + 1) / 2;
   localparam int RAD_W    = 2 * ROOT_W;
   localparam int SREM_W   = ROOT_W + 2;
   localparam int STEP_W   = $clog2(ROOT_W);
   localparam int QN_W     = MNUM_W + 1;
   localparam int RCP_SH   = QN_W + $clog2(WINDOW_LEN);
   localparam int RCP_W    = QN_W + 1;
   localparam longint RCP  = ((longint'(1) << RCP_SH) + longint'(WINDOW_LEN) - 1)
                             / longint'(WINDOW_LEN);
   localparam int PROD_W   = QN_W + RCP_W;
   localparam int ROW_W    = NCHAN * SAMPLE_W;
   localparam int RDATA_W  = ((MEAN_W + DEV_W + 7) / 8) * 8;

   typedef struct packed {
      logic full;
      logic square;
      logic accum;
      logic prep;
      logic root_init;
      logic root_step;
      logic scale;
   } lane_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ACCUM,
      ST_PREP,
      ST_VAR,
      ST_ROOT,
      ST_SCALE,
      ST_LOAD
   } state_type;

endpackage

[hw/rtl/swms_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module swms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/swms_lane.sv]
// One channel lane: running sum and square sum, bit-pair square root and
// reciprocal scaling by the window length. Depends on swms_pkg.
module swms_lane
   import swms_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  lane_ctrl_type              ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [SAMPLE_W-1:0] old_sample,
   output logic        [MEAN_W-1:0]   mean,
   output logic        [DEV_W-1:0]    deviation
);

   logic signed [SAMPLE_W-1:0] oldv_ff;
   logic        [SQ_W-1:0]     sqn_ff, sqo_ff;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic        [SQSUM_W-1:0]  sumsq_ff, sumsq_in;
   logic        [S2_W-1:0]     s2_ff;
   logic        [WQ_W-1:0]     wq_ff;
   logic                       neg_ff;
   logic        [QN_W-1:0]     mnum_ff;
   logic        [RAD_W-1:0]    rad_ff;
   logic        [SREM_W-1:0]   srem_ff;
   logic        [ROOT_W-1:0]   root_ff;
   logic        [MEAN_W-1:0]   mean_ff;
   logic        [DEV_W-1:0]    dev_ff;

   logic signed [2*SAMPLE_W-1:0] prod_new, prod_old;
   logic signed [SUM_W-1:0]      sum_neg;
   logic        [ABS_W-1:0]      abs_sum;
   logic        [WQ_W-1:0]       s2_ext, var_val;
   logic        [SREM_W+1:0]     sr, st;
   logic                         sge;
   logic        [PROD_W-1:0]     mprod, dprod;

   assign prod_new = sample * sample;
   assign prod_old = old_sample * old_sample;
   assign sum_in   = sum_ff + SUM_W'(sample) - SUM_W'(oldv_ff);
   assign sumsq_in = sumsq_ff + SQSUM_W'(sqn_ff) - SQSUM_W'(sqo_ff);
   assign sum_neg  = -sum_ff;
   assign abs_sum  = sum_ff[SUM_W-1] ? sum_neg[ABS_W-1:0] : sum_ff[ABS_W-1:0];
   assign s2_ext   = WQ_W'(s2_ff);
   assign var_val  = (wq_ff >= s2_ext) ? (wq_ff - s2_ext) : '0;

   assign sr  = {srem_ff, rad_ff[RAD_W-1 -: 2]};
   assign st  = (SREM_W+2)'({root_ff, 2'b01});
   assign sge = sr >= st;

   assign mprod = PROD_W'(mnum_ff) * PROD_W'(RCP);
   assign dprod = PROD_W'(root_ff) * PROD_W'(RCP);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
      end else if (ctrl.accum) begin
         sum_ff   <= sum_in;
         sumsq_ff <= sumsq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.square) begin
         sqn_ff  <= prod_new[SQ_W-1:0];
         sqo_ff  <= ctrl.full ? prod_old[SQ_W-1:0] : '0;
         oldv_ff <= ctrl.full ? old_sample : '0;
      end
      if (ctrl.prep) begin
         s2_ff   <= S2_W'(abs_sum) * S2_W'(abs_sum);
         wq_ff   <= WQ_W'(sumsq_ff) * WQ_W'(WINDOW_LEN);
         neg_ff  <= sum_ff[SUM_W-1];
         mnum_ff <= QN_W'({abs_sum, FRAC'(0)})
                    + (sum_ff[SUM_W-1] ? QN_W'(WINDOW_LEN - 1) : '0);
      end
      if (ctrl.root_init) begin
         rad_ff  <= RAD_W'({var_val, (2*FRAC)'(0)});
         srem_ff <= '0;
         root_ff <= '0;
      end
      if (ctrl.root_step) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         srem_ff <= sge ? SREM_W'(sr - st) : sr[SREM_W-1:0];
         root_ff <= {root_ff[ROOT_W-2:0], sge};
      end
      if (ctrl.scale) begin
         mean_ff <= mprod[RCP_SH +: MEAN_W];
         dev_ff  <= dprod[RCP_SH +: DEV_W];
      end
   end

   assign mean      = neg_ff ? -mean_ff : mean_ff;
   assign deviation = dev_ff;

endmodule

[hw/rtl/swms_merge.sv]
// Result merge: captures all lane results and sends them one channel per
// transfer. Depends on swms_pkg.
module swms_merge
   import swms_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [NCHAN-1:0][MEAN_W-1:0]   lane_mean,
   input  logic [NCHAN-1:0][DEV_W-1:0]    lane_dev,
   output logic                           busy,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [RDATA_W-1:0]             rsp_tdata,
   output logic [CHAN_W-1:0]              rsp_tuser,
   output logic                           rsp_tlast
);

   logic [NCHAN-1:0][MEAN_W-1:0] mean_ff;
   logic [NCHAN-1:0][DEV_W-1:0]  dev_ff;
   logic [CHAN_W-1:0]            idx_ff;
   logic                         busy_ff;
   logic                         last;

   assign last = idx_ff == CHAN_W'(NCHAN - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
      end else if (load) begin
         busy_ff <= 1'b1;
         idx_ff  <= '0;
      end else if (busy_ff && rsp_tready) begin
         busy_ff <= !last;
         idx_ff  <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         mean_ff <= lane_mean;
         dev_ff  <= lane_dev;
      end
   end

   assign busy       = busy_ff;
   assign rsp_tvalid = busy_ff;
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = last;
   assign rsp_tdata  = RDATA_W'({dev_ff[idx_ff], mean_ff[idx_ff]});

   assert property (@(posedge clock) disable iff (reset)
      load |-> !busy_ff) else $error("merge loaded while busy");
   assert property (@(posedge clock) disable iff (reset)
      busy_ff && rsp_tready && last |=> !busy_ff) else $error("merge overran");
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> idx_ff <= CHAN_W'(NCHAN - 1)) else $error("bad channel");

endmodule

[hw/rtl/sliding_window_mean_std_top.sv]
// Top level: sequencer, sample ring RAM, six channel lanes and result merge.
// Depends on swms_pkg, swms_ram, swms_lane, swms_merge.
//
//   channel   dir   handshake            payload
//   req       in    req_tvalid/tready    req_tdata: 6 x 16-bit samples
//   rsp       out   rsp_tvalid/tready    rsp_tdata, rsp_tuser, rsp_tlast
//
// While the window fills an item passes ST_SQUARE and ST_ACCUM; once full it
// goes on through ST_PREP, ST_VAR, ST_ROOT (the bit-pair square root in each
// lane) and ST_SCALE, then 6 result transfers that overlap the next item.
// Synchronous reset clears sums, counters and sequencer; ring is not cleared.
// Output stalls hold the merge; a finished item waits in ST_LOAD until the
// merge has sent all six results of the previous one.
module sliding_window_mean_std_top
   import swms_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z (16 bits each)
   input  logic [ROW_W-1:0]     req_tdata,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // window_mean [19:0], window_deviation [40:20], zero fill
   output logic [RDATA_W-1:0]   rsp_tdata,
   // channel
   output logic [CHAN_W-1:0]    rsp_tuser,
   output logic                 rsp_tlast
);

   state_type             state_ff, state_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [POS_W-1:0]      wpos_ff, wpos_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic                  full_ff, full_in;
   logic [ROW_W-1:0]      samp_ff;
   logic [ROW_W-1:0]      old_row;
   lane_ctrl_type         ctrl;
   logic                  accept, merge_busy, merge_load;
   logic [NCHAN-1:0][MEAN_W-1:0] lane_mean;
   logic [NCHAN-1:0][DEV_W-1:0]  lane_dev;

   assign accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         wpos_ff  <= '0;
         fill_ff  <= '0;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         wpos_ff  <= wpos_in;
         fill_ff  <= fill_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         samp_ff <= req_tdata;
      end
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      wpos_in    = wpos_ff;
      fill_in    = fill_ff;
      full_in    = full_ff;
      req_tready = 1'b0;
      merge_load = 1'b0;
      ctrl       = '0;
      ctrl.full  = full_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               full_in  = fill_ff == FILL_W'(WINDOW_LEN);
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            ctrl.square = 1'b1;
            state_in    = ST_ACCUM;
         end
         ST_ACCUM: begin
            ctrl.accum = 1'b1;
            wpos_in    = (wpos_ff == POS_W'(WINDOW_LEN - 1)) ? '0 : wpos_ff + 1'b1;
            if (!full_ff) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = (full_ff || fill_ff == FILL_W'(WINDOW_LEN - 1)) ? ST_PREP : ST_IDLE;
         end
         ST_PREP: begin
            ctrl.prep = 1'b1;
            state_in  = ST_VAR;
         end
         ST_VAR: begin
            ctrl.root_init = 1'b1;
            step_in        = '0;
            state_in       = ST_ROOT;
         end
         ST_ROOT: begin
            ctrl.root_step = 1'b1;
            step_in        = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_W - 1)) begin
               step_in  = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            ctrl.scale = 1'b1;
            state_in   = ST_LOAD;
         end
         ST_LOAD: begin
            if (!merge_busy) begin
               merge_load = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   swms_ram #(
      .WIDTH(ROW_W),
      .DEPTH(WINDOW_LEN)
   ) u_ring (
      .clock  (clock),
      .wr_en  (ctrl.square),
      .wr_addr(wpos_ff),
      .wr_data(samp_ff),
      .rd_en  (accept),
      .rd_addr(wpos_ff),
      .rd_data(old_row)
   );

   for (genvar c = 0; c < NCHAN; c++) begin : g_lane
      swms_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .sample    (samp_ff[c*SAMPLE_W +: SAMPLE_W]),
         .old_sample(old_row[c*SAMPLE_W +: SAMPLE_W]),
         .mean      (lane_mean[c]),
         .deviation (lane_dev[c])
      );
   end

   swms_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .load      (merge_load),
      .lane_mean (lane_mean),
      .lane_dev  (lane_dev),
      .busy      (merge_busy),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WINDOW_LEN)) else $error("fill count overflow");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_SQUARE) else $error("accept did not start item");
   assert property (@(posedge clock) disable iff (reset)
      wpos_ff <= POS_W'(WINDOW_LEN - 1)) else $error("ring pointer out of range");

endmodule

[bench/sliding_window_mean_std_top_test.sv]
// Testbench for sliding_window_mean_std_top: directed table, then random samples,
// checked per channel against a behavioral window sum / deviation predictor.
// Depends on swms_pkg and the block's RTL only.
module sliding_window_mean_std_top_test;
   import swms_pkg::*;

   typedef struct packed {
      logic [CHAN_W-1:0] channel;
      logic [MEAN_W-1:0] mean;
      logic [DEV_W-1:0]  deviation;
      logic              last_channel;
   } stat_type;

   logic                clock;
   logic                reset;
   logic                req_tvalid;
   logic                req_tready;
   logic [ROW_W-1:0]    req_tdata;
   logic                rsp_tvalid;
   logic                rsp_tready;
   logic [RDATA_W-1:0]  rsp_tdata;
   logic [CHAN_W-1:0]   rsp_tuser;
   logic                rsp_tlast;

   sliding_window_mean_std_top dut (.*);

   logic signed [15:0] ring [WINDOW_LEN][NCHAN];
   int                 wr_pos;
   int                 filled;
   longint             chan_sum [NCHAN];
   longint             chan_sq_sum [NCHAN];
   stat_type           stat_queue [$];
   int                 errors;

   // directed rows: pattern code selects how each sample is built
   typedef enum int { PAT_MAX, PAT_MIN, PAT_ZERO, PAT_ALT, PAT_ONES, PAT_RAND } pattern_type;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic longint root_floor(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'sh4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic predict_window(input logic [ROW_W-1:0] row);
      logic signed [15:0] x;
      longint             s;
      longint             var_num;
      longint             m;
      stat_type           st;
      for (int c = 0; c < NCHAN; c++) begin
         x = row[c*16 +: 16];
         if (filled >= WINDOW_LEN) begin
            chan_sum[c] -= ring[wr_pos][c];
            chan_sq_sum[c] -= longint'(ring[wr_pos][c]) * ring[wr_pos][c];
         end
         ring[wr_pos][c] = x;
         chan_sum[c] += x;
         chan_sq_sum[c] += longint'(x) * x;
      end
      wr_pos = (wr_pos + 1) % WINDOW_LEN;
      if (filled < WINDOW_LEN) filled++;
      if (filled < WINDOW_LEN) return;
      for (int c = 0; c < NCHAN; c++) begin
         s = chan_sum[c];
         var_num = WINDOW_LEN * chan_sq_sum[c] - s * s;
         if (var_num < 0) var_num = 0;
         m = s * 16;
         m = (m >= 0) ? m / WINDOW_LEN : -((-m + WINDOW_LEN - 1) / WINDOW_LEN);
         st.channel = CHAN_W'(c);
         st.mean = m[MEAN_W-1:0];
         st.deviation = DEV_W'(root_floor((var_num << 8) / (WINDOW_LEN * WINDOW_LEN)));
         st.last_channel = (c == NCHAN - 1);
         stat_queue.push_back(st);
      end
   endtask

   task automatic send_sample(input logic [ROW_W-1:0] row);
      int gap;
      gap = $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= row;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_window(row);
   endtask

   function automatic logic [ROW_W-1:0] build_row(pattern_type p);
      logic [ROW_W-1:0] r;
      for (int c = 0; c < NCHAN; c++) begin
         case (p)
            PAT_MAX:  r[c*16 +: 16] = 16'h7fff;
            PAT_MIN:  r[c*16 +: 16] = 16'h8000;
            PAT_ZERO: r[c*16 +: 16] = 16'h0000;
            PAT_ALT:  r[c*16 +: 16] = c[0] ? 16'h8000 : 16'h7fff;
            PAT_ONES: r[c*16 +: 16] = 16'hffff;
            default:  r[c*16 +: 16] = 16'($urandom);
         endcase
      end
      return r;
   endfunction

   // consumer: random wait per result, check each transfer against the oldest prediction
   initial begin
      stat_type exp_st;
      int       gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      @(posedge clock);
      forever begin
         gap = $urandom_range(0, 11);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (stat_queue.size() == 0) begin
            $display("%0t: expected no result, got ch %0d mean %h dev %h last %b",
               $time, rsp_tuser, rsp_tdata[19:0], rsp_tdata[40:20], rsp_tlast);
            errors++;
         end else begin
            exp_st = stat_queue.pop_front();
            if (rsp_tuser !== exp_st.channel || rsp_tdata[19:0] !== exp_st.mean
                || rsp_tdata[40:20] !== exp_st.deviation
                || rsp_tlast !== exp_st.last_channel) begin
               $display("%0t: expected ch %0d mean %h dev %h last %b,",
                  $time, exp_st.channel, exp_st.mean, exp_st.deviation,
                  exp_st.last_channel);
               $display("%0t:      got ch %0d mean %h dev %h last %b",
                  $time, rsp_tuser, rsp_tdata[19:0], rsp_tdata[40:20], rsp_tlast);
               errors++;
            end
         end
      end
   end

   pattern_type directed_rows [$];
   int          waited;

   initial begin
      errors = 0;
      wr_pos = 0;
      filled = 0;
      for (int c = 0; c < NCHAN; c++) begin
         chan_sum[c] = 0;
         chan_sq_sum[c] = 0;
      end
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // fill with extremes so the full window sees max sums and max spread
      directed_rows = '{PAT_MAX, PAT_MIN, PAT_ZERO, PAT_ALT, PAT_ONES, PAT_RAND};
      foreach (directed_rows[i]) send_sample(build_row(directed_rows[i]));
      for (int i = 0; i < WINDOW_LEN; i++) send_sample(build_row(PAT_MAX));
      // all-max window: mean 32767*16, deviation 0
      if (stat_queue.size() != 0) begin
         if (stat_queue[$].mean !== 20'h7fff0 || stat_queue[$].deviation !== 21'h0) begin
            $display("%0t: expected mean %h dev %h, got mean %h dev %h", $time,
               20'h7fff0, 21'h0, stat_queue[$].mean, stat_queue[$].deviation);
            errors++;
         end
      end
      req_tvalid <= 1'b0;
      wait (stat_queue.size() == 0);
      @(posedge clock);
      for (int i = 0; i < WINDOW_LEN; i++) send_sample(build_row(i[0] ? PAT_MIN : PAT_MAX));
      for (int i = 0; i < 224; i++) begin
         send_sample(build_row($urandom_range(0, 7) == 0 ? pattern_type'($urandom_range(0, 4))
                                                           : PAT_RAND));
         if (i == 100) begin
            req_tvalid <= 1'b0;
            wait (stat_queue.size() == 0);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      waited = 0;
      while (stat_queue.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (200) @(posedge clock);
      if (errors == 0 && stat_queue.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

[sim.f]
hw/rtl/swms_pkg.sv
hw/rtl/swms_ram.sv
hw/rtl/swms_lane.sv
hw/rtl/swms_merge.sv
hw/rtl/sliding_window_mean_std_top.sv
bench/sliding_window_mean_std_top_test.sv
